>>> hdl/cft_pkg.sv
// shared types and constants of the csv field tokenizer
package cft_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd44;
    localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'd34;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIMITER = 1'b0,
        CFG_QUOTE     = 1'b1
    } t_cfg_idx;

    // parse mode, code 3 is treated as normal
    typedef enum logic [1:0] {
        MODE_NORMAL      = 2'd0,
        MODE_IN_QUOTE    = 2'd1,
        MODE_AFTER_QUOTE = 2'd2
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_CONTENT    = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_STREAM_END = 2'd2
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] delimiter_byte;
        logic [BYTE_W-1:0] quote_byte;
    } t_cfg;

    typedef struct packed {
        t_kind             item_kind;
        logic [BYTE_W-1:0] content_byte;
        logic              line_end;
    } t_result;

endpackage

>>> hdl/cft_ifs.sv
// channel interfaces: byte input, token output, configuration writes
interface cft_in_if;
    import cft_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_input;
    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface cft_out_if;
    import cft_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] item_kind;
    logic [BYTE_W-1:0] content_byte;
    logic              line_end;
    modport source (output valid, output item_kind, output content_byte, output line_end,
                    input ready);
    modport sink   (input valid, input item_kind, input content_byte, input line_end,
                    output ready);
endinterface

interface cft_cfg_if;
    import cft_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/cft_cfg_regs.sv
// delimiter and quote configuration registers
module cft_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cft_cfg_if.sink       i_cfg,
    output cft_pkg::t_cfg o_cfg
);
    import cft_pkg::*;

    logic [BYTE_W-1:0] r_delim;
    logic [BYTE_W-1:0] r_quote;

    assign i_cfg.ready = 1'b1;

    // register write on each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
            r_quote <= QUOTE_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_DELIMITER: r_delim <= i_cfg.data;
                CFG_QUOTE:     r_quote <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_cfg.delimiter_byte = r_delim;
    assign o_cfg.quote_byte     = r_quote;

endmodule

>>> hdl/cft_parse_core.sv
// input register, parse state and per-byte token decision
module cft_parse_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cft_in_if.sink          i_in,
    input  cft_pkg::t_cfg   i_cfg,
    input  logic            i_out_free,
    output logic            o_res_valid,
    output cft_pkg::t_result o_res
);
    import cft_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_eos;

    t_mode r_mode, n_mode;
    logic  r_has_content, n_has_content;
    logic  r_last_cr, n_last_cr;

    logic advance;
    logic is_delim, is_quote, is_cr, is_lf, is_line;
    logic emit;
    t_result res;

    // an item leaves the input register whenever the result register can take it
    assign advance    = r_in_valid && i_out_free;
    assign i_in.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.in_byte;
            r_eos  <= i_in.end_of_input;
        end
    end

    // byte classification
    assign is_delim = (r_byte == i_cfg.delimiter_byte);
    assign is_quote = (r_byte == i_cfg.quote_byte);
    assign is_cr    = (r_byte == BYTE_CR);
    assign is_lf    = (r_byte == BYTE_LF);
    assign is_line  = is_cr || is_lf;

    // next parse state
    always_comb begin
        n_mode        = r_mode;
        n_has_content = r_has_content;
        n_last_cr     = r_last_cr;
        if (r_eos) begin
            n_mode        = MODE_NORMAL;
            n_has_content = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_IN_QUOTE: begin
                    if (is_quote) begin
                        n_mode = MODE_AFTER_QUOTE;
                    end else begin
                        n_has_content = 1'b1;
                    end
                end
                MODE_AFTER_QUOTE: begin
                    if (is_quote) begin
                        n_mode        = MODE_IN_QUOTE;
                        n_has_content = 1'b1;
                    end else if (is_line) begin
                        n_last_cr     = is_cr;
                        n_mode        = MODE_NORMAL;
                        n_has_content = 1'b0;
                    end else if (is_delim) begin
                        n_mode        = MODE_NORMAL;
                        n_has_content = 1'b0;
                    end
                end
                default: begin
                    // normal mode
                    if (is_delim) begin
                        n_last_cr     = 1'b0;
                        n_mode        = MODE_NORMAL;
                        n_has_content = 1'b0;
                    end else if (is_lf && !r_has_content && r_last_cr) begin
                        n_last_cr = 1'b0;
                    end else if (is_line) begin
                        n_last_cr     = is_cr;
                        n_mode        = MODE_NORMAL;
                        n_has_content = 1'b0;
                    end else if (is_quote && !r_has_content) begin
                        n_last_cr = 1'b0;
                        n_mode    = MODE_IN_QUOTE;
                    end else begin
                        n_last_cr     = 1'b0;
                        n_has_content = 1'b1;
                    end
                end
            endcase
        end
    end

    // token produced by this byte
    always_comb begin
        emit             = 1'b0;
        res.item_kind    = KIND_CONTENT;
        res.content_byte = '0;
        res.line_end     = 1'b0;
        if (r_eos) begin
            emit          = 1'b1;
            res.item_kind = r_has_content ? KIND_FIELD_END : KIND_STREAM_END;
        end else begin
            unique case (r_mode)
                MODE_IN_QUOTE: begin
                    if (!is_quote) begin
                        emit             = 1'b1;
                        res.content_byte = r_byte;
                    end
                end
                MODE_AFTER_QUOTE: begin
                    if (is_quote) begin
                        emit             = 1'b1;
                        res.content_byte = r_byte;
                    end else if (is_line || is_delim) begin
                        emit          = 1'b1;
                        res.item_kind = KIND_FIELD_END;
                        res.line_end  = is_line;
                    end
                end
                default: begin
                    if (is_delim) begin
                        emit          = 1'b1;
                        res.item_kind = KIND_FIELD_END;
                    end else if (is_lf && !r_has_content && r_last_cr) begin
                        emit = 1'b0;
                    end else if (is_line) begin
                        emit          = 1'b1;
                        res.item_kind = KIND_FIELD_END;
                        res.line_end  = 1'b1;
                    end else if (!(is_quote && !r_has_content)) begin
                        emit             = 1'b1;
                        res.content_byte = r_byte;
                    end
                end
            endcase
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_NORMAL;
            r_has_content <= 1'b0;
            r_last_cr     <= 1'b0;
        end else if (advance) begin
            r_mode        <= n_mode;
            r_has_content <= n_has_content;
            r_last_cr     <= n_last_cr;
        end
    end

    assign o_res_valid = advance && emit;
    assign o_res       = res;

endmodule

>>> hdl/cft_out_reg.sv
// result register driving the output channel
module cft_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  cft_pkg::t_result i_res,
    output logic             o_free,
    cft_out_if.source        o_out
);
    import cft_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held result is taken this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.item_kind    = r_res.item_kind;
    assign o_out.content_byte = r_res.content_byte;
    assign o_out.line_end     = r_res.line_end;

endmodule

>>> hdl/csv_field_tokenizer.sv
// top level of the csv field tokenizer
// Byte-serial CSV tokenizer with quoted fields.
// i_in: one request per raw byte, or an end-of-stream mark (end_of_input).
// o_out: at most one token per input request: a content byte, an end of
//   field (line_end set when the field also ends a line) or an end of stream.
// i_cfg: delimiter (index 0) and quote byte (index 1), always ready; write
//   only while no byte is in flight.
// Path: an accepted byte is held in the input register, then its token in the
//   result register, which drives the output.
// Throughput: one byte per cycle while the output is not held; the parse state
//   is a two-bit mode and two flags updated together, so bytes follow back to back.
// Bytes that make no token leave the input register at the next edge unless
//   the result register is held.
// Stall: while the output is held, the result register keeps its token and
//   the input register holds one more byte; input ready falls only when both
//   are full, and nothing is dropped.
// Reset (synchronous, active low): normal mode, no field content, no CR
//   pending, both channels empty, delimiter ',' and quote '"'.
module csv_field_tokenizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cft_in_if.sink    i_in,
    cft_cfg_if.sink   i_cfg,
    cft_out_if.source o_out
);
    import cft_pkg::*;

    t_cfg    cfg;
    t_result res;
    logic    res_valid;
    logic    out_free;

    // configuration registers
    cft_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // parser
    cft_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (cfg),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output stage
    cft_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_out       (o_out)
    );

endmodule
